FILE: design/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, codes and helpers of the ring node election/token controller.
// ----------------------------------------------------------------------------
package rne_pkg;

	localparam int ID_W         = 16;
	localparam int WORD_W       = 32;
	localparam int SEQ_BITS_DEF = 32;
	localparam int IN_TDATA_W   = 120;
	localparam int IN_TUSER_W   = 4;
	localparam int OUT_TDATA_W  = 112;
	localparam int OUT_TUSER_W  = 5;
	localparam int OBUF_DEPTH   = 4;

	typedef enum logic [3:0] {
		OP_PROBE     = 4'd0,
		OP_ACK       = 4'd1,
		OP_NAK       = 4'd2,
		OP_ELECTION  = 4'd3,
		OP_ELECTED   = 4'd4,
		OP_TOKEN     = 4'd5,
		OP_TEXT      = 4'd6,
		OP_RECOVER   = 4'd7,
		OP_JOIN      = 4'd8,
		OP_ELEC_TMR  = 4'd9,
		OP_LOSS_TMO  = 4'd10,
		OP_LEAVE     = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		KIND_PROBE    = 3'd0,
		KIND_ACK      = 3'd1,
		KIND_NAK      = 3'd2,
		KIND_ELECTION = 3'd3,
		KIND_ELECTED  = 3'd4,
		KIND_TOKEN    = 3'd5,
		KIND_TEXT     = 3'd6,
		KIND_RECOVER  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NEXT  = 2'd0,
		MODE_BCAST = 2'd1,
		MODE_DEST  = 2'd2
	} dest_mode_t;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   src;
		logic [WORD_W-1:0] mseq;
		logic [ID_W-1:0]   cand;
		logic [WORD_W-1:0] tag;
		logic [ID_W-1:0]   lsend;
		logic              ready;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		dest_mode_t        mode;
		logic [ID_W-1:0]   dest;
		logic [ID_W-1:0]   source;
		logic [WORD_W-1:0] seq_num;
		logic [ID_W-1:0]   candidate;
		logic [WORD_W-1:0] election;
		logic              last;
	} msg_t;

	typedef struct packed {
		logic [ID_W-1:0]   next_hop;
		logic              next_known;
		logic [ID_W-1:0]   prev_hop;
		logic              prev_known;
		logic              election_pending;
		logic [ID_W-1:0]   leader_id;
		logic              token_known;
		logic              sending_now;
		logic [ID_W-1:0]   token_client;
		logic [WORD_W-1:0] token_number;
	} node_state_t;

	function automatic msg_t mk_msg(kind_t k, dest_mode_t m, logic [ID_W-1:0] dest,
			logic [ID_W-1:0] src, logic [WORD_W-1:0] sq, logic [ID_W-1:0] cand,
			logic [WORD_W-1:0] elec);
		msg_t r;
		r.kind      = k;
		r.mode      = m;
		r.dest      = dest;
		r.source    = src;
		r.seq_num   = sq;
		r.candidate = cand;
		r.election  = elec;
		r.last      = 1'b0;
		return r;
	endfunction

endpackage

FILE: design/rne_step.sv
// ----------------------------------------------------------------------------
// rne_step
// Per-word decode: next node state and up to two outgoing messages.
// ----------------------------------------------------------------------------
module rne_step import rne_pkg::*; #(
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  logic [ID_W-1:0]     my_id,
	input  node_state_t         st,
	input  logic [SEQ_BITS-1:0] seq_q,
	input  logic [SEQ_BITS-1:0] probe_q,
	input  item_t               it,
	output node_state_t         st_nxt,
	output logic [SEQ_BITS-1:0] seq_nxt,
	output logic [SEQ_BITS-1:0] probe_nxt,
	output msg_t                msg0,
	output msg_t                msg1,
	output logic [1:0]          nres
);

	function automatic logic may_be_next(logic [ID_W-1:0] s, logic [ID_W-1:0] me,
			node_state_t x);
		return !x.next_known ||
			(s > me && s < x.next_hop) ||
			(x.next_hop < me && s < x.next_hop) ||
			(x.next_hop < me && me < s);
	endfunction

	// local text if due, otherwise pass the token
	function automatic msg_t text_or_token(logic rdy, logic [ID_W-1:0] me,
			logic [WORD_W-1:0] sq, logic [ID_W-1:0] client, logic [WORD_W-1:0] num);
		if (rdy)
			return mk_msg(KIND_TEXT, MODE_NEXT, '0, me, sq, '0, '0);
		return mk_msg(KIND_TOKEN, MODE_NEXT, '0, client, '0, '0, num);
	endfunction

	logic [WORD_W-1:0] seq_w;
	logic [WORD_W-1:0] seq_w1;

	assign seq_w  = WORD_W'(seq_q);
	assign seq_w1 = WORD_W'(seq_q + SEQ_BITS'(1));

	always_comb begin
		logic pb;
		logic acc;
		msg_t reply;
		st_nxt    = st;
		seq_nxt   = seq_q;
		probe_nxt = probe_q;
		msg0      = '0;
		msg1      = '0;
		nres      = 2'd0;
		pb        = 1'b0;
		acc       = 1'b0;
		reply     = '0;
		unique case (it.op)
			OP_PROBE: begin
				pb = may_be_next(it.src, my_id, st) &&
					!(st.prev_known && it.src == st.prev_hop);
				acc = !st.prev_known || it.src == st.prev_hop ||
					(it.src > st.prev_hop && it.src < my_id) ||
					(my_id < st.prev_hop && it.src < my_id) ||
					(my_id < st.prev_hop && it.src > st.prev_hop);
				if (acc) begin
					st_nxt.prev_hop   = it.src;
					st_nxt.prev_known = 1'b1;
					reply = mk_msg(KIND_ACK, MODE_DEST, it.src, my_id, it.mseq, '0, '0);
				end else begin
					reply = mk_msg(KIND_NAK, MODE_DEST, it.src, my_id, it.mseq, '0, '0);
				end
				if (pb) begin
					msg0 = mk_msg(KIND_PROBE, MODE_BCAST, '0, my_id, seq_w, '0, '0);
					msg1 = reply;
					nres = 2'd2;
					probe_nxt = seq_q;
					st_nxt.election_pending = 1'b0;
					st_nxt.next_known = 1'b0;
					seq_nxt = seq_q + SEQ_BITS'(2);
				end else begin
					msg0 = reply;
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
				end
			end
			OP_ACK: begin
				if (it.mseq == WORD_W'(probe_q) && may_be_next(it.src, my_id, st)) begin
					st_nxt.next_hop = it.src;
					st_nxt.next_known = 1'b1;
					st_nxt.election_pending = 1'b1;
				end
			end
			OP_ELECTION: begin
				if (st.next_known) begin
					if (it.cand == my_id) begin
						st_nxt.leader_id = it.cand;
						msg0 = mk_msg(KIND_ELECTED, MODE_NEXT, '0, it.src, '0, it.cand,
							it.tag);
					end else begin
						msg0 = mk_msg(KIND_ELECTION, MODE_NEXT, '0, it.src, '0,
							(my_id > it.cand) ? my_id : it.cand, it.tag);
					end
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
				end
			end
			OP_ELECTED: begin
				if (!st.token_known) begin
					st_nxt.leader_id = it.cand;
					if (it.cand == my_id) begin
						st_nxt.token_client = my_id;
						st_nxt.token_number = it.tag;
						st_nxt.token_known = 1'b1;
						st_nxt.sending_now = it.ready;
						msg0 = text_or_token(it.ready, my_id, seq_w, my_id, it.tag);
					end else begin
						msg0 = mk_msg(KIND_ELECTED, MODE_NEXT, '0, it.src, '0, it.cand,
							it.tag);
					end
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
				end
			end
			OP_TOKEN: begin
				st_nxt.token_client = it.src;
				st_nxt.token_number = it.tag;
				st_nxt.token_known = 1'b1;
				st_nxt.sending_now = it.ready;
				msg0 = text_or_token(it.ready, my_id, seq_w, it.src, it.tag);
				nres = 2'd1;
				seq_nxt = seq_q + SEQ_BITS'(1);
			end
			OP_TEXT: begin
				if (st.prev_known && it.lsend == st.prev_hop) begin
					if (it.src == my_id) begin
						st_nxt.sending_now = st.sending_now & it.ready;
						msg0 = text_or_token(it.ready, my_id, seq_w, st.token_client,
							st.token_number);
					end else begin
						msg0 = mk_msg(KIND_TEXT, MODE_NEXT, '0, it.src, it.mseq, '0, '0);
					end
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
				end
			end
			OP_RECOVER: begin
				if (it.src != my_id) begin
					msg0 = mk_msg(KIND_RECOVER, MODE_NEXT, '0, it.src, '0, '0, '0);
					msg1 = mk_msg(KIND_PROBE, MODE_BCAST, '0, my_id, seq_w1, '0, '0);
					nres = 2'd2;
					probe_nxt = seq_q + SEQ_BITS'(1);
					st_nxt.election_pending = 1'b0;
					st_nxt.next_known = 1'b0;
					seq_nxt = seq_q + SEQ_BITS'(2);
				end
			end
			OP_JOIN: begin
				msg0 = mk_msg(KIND_PROBE, MODE_BCAST, '0, my_id, seq_w, '0, '0);
				nres = 2'd1;
				probe_nxt = seq_q;
				st_nxt.election_pending = 1'b0;
				st_nxt.next_known = 1'b0;
				seq_nxt = seq_q + SEQ_BITS'(1);
			end
			OP_ELEC_TMR: begin
				if (st.election_pending) begin
					st_nxt.election_pending = 1'b0;
					msg0 = mk_msg(KIND_ELECTION, MODE_NEXT, '0, my_id, '0, my_id, it.tag);
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
				end
			end
			OP_LOSS_TMO: begin
				st_nxt.prev_known = 1'b0;
				st_nxt.election_pending = 1'b0;
				st_nxt.next_known = 1'b0;
				st_nxt.sending_now = 1'b0;
				st_nxt.token_known = 1'b0;
				msg0 = mk_msg(KIND_PROBE, MODE_BCAST, '0, my_id, seq_w, '0, '0);
				msg1 = mk_msg(KIND_RECOVER, MODE_NEXT, '0, my_id, '0, '0, '0);
				nres = 2'd2;
				probe_nxt = seq_q;
				seq_nxt = seq_q + SEQ_BITS'(2);
			end
			OP_LEAVE: begin
				if (st.sending_now) begin
					msg0 = mk_msg(KIND_TOKEN, MODE_NEXT, '0, st.token_client, '0, '0,
						st.token_number);
					nres = 2'd1;
					seq_nxt = seq_q + SEQ_BITS'(1);
					st_nxt.sending_now = 1'b0;
					st_nxt.token_known = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (nres == 2'd1)
			msg0.last = 1'b1;
		if (nres == 2'd2)
			msg1.last = 1'b1;
	end

endmodule

FILE: design/ring_node_election_token.sv
// ----------------------------------------------------------------------------
// ring_node_election_token
// Ring node controller: neighbor discovery, max-id election, token passing.
// Result path: an input word is held in the input register; its result words
// then enter the output queue. Throughput: one input word per cycle while the
// queue has room; two-result words are bounded by the output port, one result
// word per cycle while m_axis_tready is high, via a four-entry output queue.
// Reset: all node state and my_id clear to zero; the queue empties.
// ----------------------------------------------------------------------------
module ring_node_election_token import rne_pkg::*; #(
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ID_W-1:0]        cfg_data,      // my_id
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// src_node, msg_seq, best_candidate, election_tag, link_sender, text_ready
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // operation
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_dest, out_source, out_sequence, out_candidate, out_election
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // out_kind, out_dest_mode
	output logic                   m_axis_tlast
);

	localparam int PTR_W = $clog2(OBUF_DEPTH);
	localparam int CNT_W = $clog2(OBUF_DEPTH + 1);

	logic [ID_W-1:0]     my_id_q;
	node_state_t         st_q;
	node_state_t         st_nxt;
	logic [SEQ_BITS-1:0] seq_q;
	logic [SEQ_BITS-1:0] seq_nxt;
	logic [SEQ_BITS-1:0] probe_q;
	logic [SEQ_BITS-1:0] probe_nxt;
	item_t               item_s1;
	logic                valid_s1;
	msg_t                msg0;
	msg_t                msg1;
	logic [1:0]          nres;
	logic                fire;
	logic                pop;
	msg_t                obuf [OBUF_DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W-1:0]    cnt_q;
	msg_t                head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			my_id_q <= '0;
		else if (cfg_valid)
			my_id_q <= cfg_data;
	end

	// input register
	assign fire          = valid_s1 && (cnt_q <= CNT_W'(OBUF_DEPTH) - CNT_W'(nres));
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op    <= op_t'(s_axis_tuser);
			item_s1.src   <= s_axis_tdata[15:0];
			item_s1.mseq  <= s_axis_tdata[47:16];
			item_s1.cand  <= s_axis_tdata[63:48];
			item_s1.tag   <= s_axis_tdata[95:64];
			item_s1.lsend <= s_axis_tdata[111:96];
			item_s1.ready <= s_axis_tdata[112];
		end
	end

	rne_step #(
		.SEQ_BITS (SEQ_BITS)
	) u_step (
		.my_id     (my_id_q),
		.st        (st_q),
		.seq_q     (seq_q),
		.probe_q   (probe_q),
		.it        (item_s1),
		.st_nxt    (st_nxt),
		.seq_nxt   (seq_nxt),
		.probe_nxt (probe_nxt),
		.msg0      (msg0),
		.msg1      (msg1),
		.nres      (nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			seq_q   <= '0;
			probe_q <= '0;
		end else if (fire) begin
			st_q    <= st_nxt;
			seq_q   <= seq_nxt;
			probe_q <= probe_nxt;
		end
	end

	// output queue
	assign pop  = (cnt_q != '0) && m_axis_tready;
	assign head = obuf[rd_q];

	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0)
			obuf[wr_q] <= msg0;
		if (fire && nres == 2'd2)
			obuf[wr_q + PTR_W'(1)] <= msg1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (fire)
				wr_q <= wr_q + PTR_W'(nres);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (fire ? CNT_W'(nres) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = {head.election, head.candidate, head.seq_num, head.source,
		head.dest};
	assign m_axis_tuser  = {head.mode, head.kind};
	assign m_axis_tlast  = head.last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OBUF_DEPTH))
		else $error("output queue overfilled");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		fire && nres != 2'd0 |=> m_axis_tvalid)
		else $error("pushed result not visible");

	a_elect_needs_next: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.election_pending |-> st_q.next_known)
		else $error("election pending without successor");

	a_send_needs_token: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.sending_now |-> st_q.token_known)
		else $error("sending without token");
`endif

endmodule
